// File: rtl/core/nmea_sentence_checker_defines.svh
// ----------------------------------------------------------------------------
// nmea_sentence_checker_defines.svh
// Assertion macros shared by the NMEA sentence checker RTL.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define NSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define NSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// Types, character codes and helper functions for the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

  // Length limit; the count register is 8 bits so the cap never exceeds 255
  localparam int MAX_LENGTH = 255;
  localparam int LEN_CAP_INT = (MAX_LENGTH < 255) ? MAX_LENGTH : 255;
  localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CASE_BIAS = 8'h20;

  localparam logic [7:0] NIB_HI_MASK = 8'hF0;
  localparam logic [7:0] NIB_LO_MASK = 8'h0F;

  // Header strings, first character in element 0
  typedef logic [7:0] hdr_t [5];
  localparam hdr_t HDR_RMC = '{8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43}; // GNRMC
  localparam hdr_t HDR_GGA = '{8'h47, 8'h4E, 8'h47, 8'h47, 8'h41}; // GNGGA

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NO_STAR  = 2'd1,
    STS_MISMATCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_RMC   = 2'd1,
    KIND_GGA   = 2'd2
  } kind_t;

  // Upper-case ASCII hex digit for a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

  // Fold lower-case a..f onto upper case, everything else unchanged
  function automatic logic [7:0] fold_hex(input logic [7:0] c);
    logic [7:0] r;
    if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      r = c - CASE_BIAS;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/nmea_sentence_checker.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// Checks NMEA 0183 sentences in a byte stream: star position, hex checksum
// (either case), header kind and saturating length.
// ----------------------------------------------------------------------------
// One byte is taken every clock cycle unless the input is stalled. A byte
// waits in the input register, where the sentence state (running XOR,
// last-three-byte window, header characters, length count) is updated; a
// carriage return that closes a sentence then loads the result register
// once that register is free. A held output stalls the input only while
// both registers are full. Bytes outside a sentence, other than '$', give
// no result.

`include "nmea_sentence_checker_defines.svh"

module nmea_sentence_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_computed_checksum,
  output logic [1:0] out_sentence_kind,
  output logic [7:0] out_sentence_length
);

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  // Sentence state
  logic       in_sentence_r, in_sentence_nxt;
  logic [7:0] run_xor_r, run_xor_nxt;
  logic [7:0] recent_r [3];
  logic [7:0] recent_nxt [3];
  logic [7:0] header_r [5];
  logic [7:0] header_nxt [5];
  logic [7:0] byte_count_r, byte_count_nxt;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [7:0] out_sum_r, out_sum_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [7:0] out_len_r, out_len_nxt;

  logic       out_free;
  logic       s1_adv;
  logic       is_close;
  logic [7:0] sum;
  logic       star_bad;
  logic       hex_bad;
  logic       is_rmc;
  logic       is_gga;
  nsc_pkg::status_t status;
  nsc_pkg::kind_t   kind;

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  // Checks for a closing carriage return
  assign is_close = in_sentence_r && (s1_byte_r == nsc_pkg::CH_CR);
  assign sum      = run_xor_r ^ recent_r[0] ^ recent_r[1] ^ recent_r[2];
  assign star_bad = (byte_count_r < 8'd4) || (recent_r[0] != nsc_pkg::CH_STAR);
  assign hex_bad  =
      (nsc_pkg::fold_hex(recent_r[1]) !=
       nsc_pkg::hex_char(4'((sum & nsc_pkg::NIB_HI_MASK) >> 4))) ||
      (nsc_pkg::fold_hex(recent_r[2]) !=
       nsc_pkg::hex_char(4'(sum & nsc_pkg::NIB_LO_MASK)));

  always_comb begin
    is_rmc = 1'b1;
    is_gga = 1'b1;
    for (int i = 0; i < 5; i++) begin
      if (header_r[i] != nsc_pkg::HDR_RMC[i]) is_rmc = 1'b0;
      if (header_r[i] != nsc_pkg::HDR_GGA[i]) is_gga = 1'b0;
    end
  end

  always_comb begin
    priority if (star_bad) begin
      status = nsc_pkg::STS_NO_STAR;
    end else if (hex_bad) begin
      status = nsc_pkg::STS_MISMATCH;
    end else begin
      status = nsc_pkg::STS_OK;
    end
  end

  always_comb begin
    kind = nsc_pkg::KIND_OTHER;
    if (status == nsc_pkg::STS_OK && byte_count_r >= 8'd6) begin
      priority if (is_rmc) begin
        kind = nsc_pkg::KIND_RMC;
      end else if (is_gga) begin
        kind = nsc_pkg::KIND_GGA;
      end else begin
        kind = nsc_pkg::KIND_OTHER;
      end
    end
  end

  // Sentence state update
  always_comb begin
    in_sentence_nxt = in_sentence_r;
    run_xor_nxt     = run_xor_r;
    recent_nxt      = recent_r;
    header_nxt      = header_r;
    byte_count_nxt  = byte_count_r;
    if (s1_adv) begin
      if (!in_sentence_r) begin
        if (s1_byte_r == nsc_pkg::CH_DOLLAR) begin
          in_sentence_nxt = 1'b1;
          run_xor_nxt     = '0;
          recent_nxt      = '{default: '0};
          header_nxt      = '{default: '0};
          byte_count_nxt  = 8'd1;
        end
      end else if (is_close) begin
        in_sentence_nxt = 1'b0;
      end else begin
        run_xor_nxt   = run_xor_r ^ s1_byte_r;
        recent_nxt[0] = recent_r[1];
        recent_nxt[1] = recent_r[2];
        recent_nxt[2] = s1_byte_r;
        for (int i = 0; i < 5; i++) begin
          if (byte_count_r == 8'(i + 1)) header_nxt[i] = s1_byte_r;
        end
        if (byte_count_r < nsc_pkg::LEN_CAP) begin
          byte_count_nxt = byte_count_r + 8'd1;
        end
      end
    end
  end

  // Result register load
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_sum_nxt    = out_sum_r;
    out_kind_nxt   = out_kind_r;
    out_len_nxt    = out_len_r;
    if (out_free) begin
      out_valid_nxt  = s1_valid_r && is_close;
      out_status_nxt = status;
      out_sum_nxt    = sum;
      out_kind_nxt   = kind;
      out_len_nxt    = byte_count_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      in_sentence_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      in_sentence_r <= in_sentence_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload and sentence data registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= in_data_byte;
    end
    run_xor_r    <= run_xor_nxt;
    recent_r     <= recent_nxt;
    header_r     <= header_nxt;
    byte_count_r <= byte_count_nxt;
    out_status_r <= out_status_nxt;
    out_sum_r    <= out_sum_nxt;
    out_kind_r   <= out_kind_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_computed_checksum = out_sum_r;
  assign out_sentence_kind     = out_kind_r;
  assign out_sentence_length   = out_len_r;

  // Assertions
  `NSC_ASSERT_NEXT(a_close_gives_result, s1_adv && is_close, out_valid_r, "CR lost its result")
  `NSC_ASSERT_NEXT(a_open_only_on_dollar,
    s1_adv && !in_sentence_r && s1_byte_r != nsc_pkg::CH_DOLLAR,
    !in_sentence_r, "sentence opened without dollar")
  `NSC_ASSERT_SAME(a_kind_needs_ok,
    out_valid_r && out_kind_r != nsc_pkg::KIND_OTHER,
    out_status_r == nsc_pkg::STS_OK, "kind reported on a bad sentence")
  `NSC_ASSERT_SAME(a_ok_min_length, out_valid_r && out_status_r == nsc_pkg::STS_OK,
    out_len_r >= 8'd4, "ok status on a short sentence")
  `NSC_ASSERT_SAME(a_count_capped, in_sentence_r,
    byte_count_r <= nsc_pkg::LEN_CAP && byte_count_r != 8'd0, "length count out of range")

endmodule

// File: tb/sv/nmea_sentence_checker_tb_pkg.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checker_tb_pkg
// Scoreboard for the NMEA sentence checker: follows the byte stream, builds
// the expected sentence report for every closing carriage return and checks
// the reports that the block gives, in order.
// ----------------------------------------------------------------------------
package nsc_tb_pkg;

  import nsc_pkg::*;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam int         PRINT_LIMIT   = 60;

  // One sentence report as the block presents it
  typedef struct {
    status_t    status;
    logic [7:0] checksum;
    kind_t      kind;
    logic [7:0] length;
  } sentence_report_t;

  class sentence_scoreboard;

    // Sentence tracking state
    bit         open;
    logic [7:0] xor_acc;
    logic [7:0] tail [3];   // [0] oldest, [2] newest
    hdr_t       head;
    logic [7:0] count;

    sentence_report_t due_reports [$];
    int unsigned      mismatch_count;

    function new();
      open           = 1'b0;
      xor_acc        = '0;
      count          = '0;
      mismatch_count = 0;
      foreach (tail[i]) tail[i] = '0;
      foreach (head[i]) head[i] = '0;
    endfunction

    // A checksum digit matches when it is the nibble in upper case, or a
    // lower-case letter for nibbles ten and up
    function bit digit_ok(logic [7:0] got, logic [3:0] nib);
      logic [7:0] upper;
      upper = (nib < 4'd10) ? ASCII_ZERO + 8'(nib) : ASCII_UPPER_A + 8'(nib) - 8'd10;
      return (got == upper) || (nib >= 4'd10 && got == (upper | CASE_BIAS));
    endfunction

    function bit header_is(hdr_t want);
      for (int i = 0; i < 5; i++) begin
        if (head[i] != want[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Called for every accepted input transaction
    function void note_byte(logic [7:0] b);
      sentence_report_t r;
      logic [7:0] sum;
      if (!open) begin
        // outside a sentence only a dollar matters
        if (b == CH_DOLLAR) begin
          open    = 1'b1;
          xor_acc = '0;
          foreach (tail[i]) tail[i] = '0;
          foreach (head[i]) head[i] = '0;
          count = (LEN_CAP > 8'd1) ? 8'd1 : LEN_CAP;
        end
      end else if (b == CH_CR) begin
        // close: the last three bytes are the star and two digits
        sum        = xor_acc ^ tail[0] ^ tail[1] ^ tail[2];
        r.checksum = sum;
        r.length   = count;
        r.kind     = KIND_OTHER;
        if (count < 8'd4 || tail[0] != CH_STAR) begin
          r.status = STS_NO_STAR;
        end else if (!digit_ok(tail[1], sum[7:4]) || !digit_ok(tail[2], sum[3:0])) begin
          r.status = STS_MISMATCH;
        end else begin
          r.status = STS_OK;
        end
        if (r.status == STS_OK && count >= 8'd6) begin
          if (header_is(HDR_RMC)) begin
            r.kind = KIND_RMC;
          end else if (header_is(HDR_GGA)) begin
            r.kind = KIND_GGA;
          end
        end
        due_reports.push_back(r);
        open = 1'b0;
      end else begin
        // ordinary data byte, dollar and line feed included
        xor_acc ^= b;
        tail[0] = tail[1];
        tail[1] = tail[2];
        tail[2] = b;
        if (count >= 8'd1 && count <= 8'd5) head[count - 8'd1] = b;
        if (count < LEN_CAP) count++;
      end
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
        $display("%0t MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    // Called for every accepted result transaction
    task check_result(logic [1:0] status, logic [7:0] checksum,
                      logic [1:0] kind, logic [7:0] length);
      sentence_report_t want;
      if (due_reports.size() == 0) begin
        report("report with no sentence closed", {6'd0, status}, 8'd0);
      end else begin
        want = due_reports.pop_front();
        if (status !== want.status)
          report("status", {6'd0, status}, {6'd0, want.status});
        if (checksum !== want.checksum)
          report("computed_checksum", checksum, want.checksum);
        if (kind !== want.kind)
          report("sentence_kind", {6'd0, kind}, {6'd0, want.kind});
        if (length !== want.length)
          report("sentence_length", length, want.length);
      end
    endtask

  endclass

endpackage

// File: tb/sv/nmea_sentence_checker_tb.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checker_tb
// Drives byte streams into the NMEA sentence checker: a few hand-made
// sentences, then random well-formed sentences with random content mixed
// with broken ones and line noise, under three idle/stall patterns. Every
// report is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import nsc_pkg::*;
  import nsc_tb_pkg::*;

  localparam int ITEM_TARGET     = 750;
  localparam int SENTENCE_TARGET = 40;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_computed_checksum;
  logic [1:0] out_sentence_kind;
  logic [7:0] out_sentence_length;

  sentence_scoreboard sb;
  int send_idle_pct = 26;
  int recv_idle_pct = 82;
  int bytes_sent = 0;
  int sentences_sent = 0;
  int quiet_cycles = 0;

  nmea_sentence_checker dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_computed_checksum(out_computed_checksum),
    .out_sentence_kind    (out_sentence_kind),
    .out_sentence_length  (out_sentence_length)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_data_byte);
      if (out_valid && !out_stall)
        sb.check_result(out_status, out_computed_checksum, out_sentence_kind,
                        out_sentence_length);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
        $display("nmea_sentence_checker_tb: done, errors");
        $finish;
      end
    end
  end

  // One byte through the input handshake, with random idle cycles first
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_byte(t[i]);
  endtask

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib, input bit lower);
    string digits;
    logic [7:0] c;
    digits = "0123456789ABCDEF";
    c = digits[nib];
    if (lower && nib > 4'd9) c = c | CASE_BIAS;
    return c;
  endfunction

  // Random data byte, never a carriage return; dollar, line feed, NUL and
  // star show up more often than chance
  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    case ($urandom_range(0, 19))
      0:       b = CH_DOLLAR;
      1:       b = 8'h0A;
      2:       b = 8'h00;
      3:       b = CH_STAR;
      default: b = 8'($urandom_range(0, 255));
    endcase
    if (b == CH_CR) b = 8'hFF;
    return b;
  endfunction

  // Sentence with a random header and body and a mostly correct trailer
  task automatic send_random_sentence(input bit go_long);
    logic [7:0] line [$];
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] bad;
    int hdr_pick;
    int hdr_len;
    int miss_at;
    int body_len;
    int shape;
    sum      = '0;
    hdr_pick = $urandom_range(0, 9);
    hdr_len  = (hdr_pick == 7) ? $urandom_range(0, 4) : 5;
    miss_at  = $urandom_range(0, 4);
    body_len = go_long ? $urandom_range(250, 270) : $urandom_range(0, 10);
    line.push_back(CH_DOLLAR);

    // header: the two known kinds, a near miss, short or random
    for (int i = 0; i < hdr_len; i++) begin
      case (hdr_pick)
        0, 1, 2: b = HDR_RMC[i];
        3, 4, 5: b = HDR_GGA[i];
        6:       b = (i == miss_at) ? HDR_RMC[i] ^ 8'(1 << $urandom_range(0, 7)) : HDR_RMC[i];
        default: b = data_byte();
      endcase
      if (b == CH_CR) b = 8'h8D;
      line.push_back(b);
      sum ^= b;
    end

    for (int i = 0; i < body_len; i++) begin
      b = data_byte();
      line.push_back(b);
      sum ^= b;
    end

    // trailer
    shape = $urandom_range(0, 99);
    if (shape < 72) begin
      line.push_back(CH_STAR);
      line.push_back(hex_ascii(sum[7:4], 1'($urandom_range(0, 1))));
      line.push_back(hex_ascii(sum[3:0], 1'($urandom_range(0, 1))));
    end else if (shape < 82) begin
      bad = sum ^ 8'(1 << $urandom_range(0, 7));
      line.push_back(CH_STAR);
      line.push_back(hex_ascii(bad[7:4], 1'($urandom_range(0, 1))));
      line.push_back(hex_ascii(bad[3:0], 1'($urandom_range(0, 1))));
    end else if (shape < 88) begin
      line.push_back(data_byte());
      line.push_back(data_byte());
    end else if (shape < 94) begin
      line.push_back(CH_STAR);
      line.push_back(hex_ascii(sum[7:4], 1'b0));
    end else begin
      line.push_back(CH_STAR);
      line.push_back(data_byte());
      line.push_back(data_byte());
    end
    line.push_back(CH_CR);
    if ($urandom_range(0, 9) < 4) line.push_back(8'h0A);

    // line noise between sentences, never a dollar
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_DOLLAR) b = 8'h00;
        line.push_back(b);
      end
    end

    foreach (line[i]) send_byte(line[i]);
    sentences_sent++;
  endtask

  initial begin
    int phase;
    phase = 0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: noise outside a sentence, an empty sentence, lower-case
    // digits, a wrong checksum and a GNRMC header
    send_byte(8'h0A);
    send_byte(8'hFF);
    send_text("$\015");
    send_text("$J*4a\015");
    send_text("$J*4B\015");
    send_text("$GNRMC*55\015");

    // Random sentences under three idle/stall patterns
    while (bytes_sent < ITEM_TARGET || sentences_sent < SENTENCE_TARGET) begin
      if (phase == 0 && bytes_sent >= ITEM_TARGET / 3) begin
        phase         = 1;
        send_idle_pct = 82;
        recv_idle_pct = 26;
      end
      if (phase == 1 && bytes_sent >= 2 * ITEM_TARGET / 3) begin
        phase         = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // one sentence long enough to saturate the length count
        send_random_sentence(1'b1);
      end
      send_random_sentence(1'b0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("nmea_sentence_checker_tb: done, clean");
    end else begin
      $display("nmea_sentence_checker_tb: done, errors");
    end
    $finish;
  end

endmodule
